@@ hdl/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV sphere triangle generator
// Holds the transfer payload types, the command passed from the front end to
// the back end, the configuration register map and the fixed sine table.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int PHASE_W     = 5;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = 1;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_CENTER_X = 2'd0;
    localparam cfg_index_t CFG_CENTER_Y = 2'd1;
    localparam cfg_index_t CFG_CENTER_Z = 2'd2;
    localparam cfg_index_t CFG_RADIUS   = 2'd3;

    localparam logic [14:0] RADIUS_RESET = 15'd512;

    typedef logic [PHASE_W-1:0] phase_t;

    // Polar phases of the two poles: sine is zero, cosine is +1 or -1.
    localparam phase_t TH_NORTH = 5'd0;
    localparam phase_t TH_SOUTH = 5'd16;
    localparam phase_t PH_POLE  = 5'd0;
    localparam phase_t QUARTER  = 5'd8;

    typedef logic signed [15:0] sine_t;

    // Full-wave sine in Q1.14, 32 steps per turn.
    localparam sine_t SINE_TABLE [32] = '{
        16'sd0,      16'sd3196,   16'sd6270,   16'sd9102,
        16'sd11585,  16'sd13623,  16'sd15137,  16'sd16069,
        16'sd16384,  16'sd16069,  16'sd15137,  16'sd13623,
        16'sd11585,  16'sd9102,   16'sd6270,   16'sd3196,
        16'sd0,      -16'sd3196,  -16'sd6270,  -16'sd9102,
        -16'sd11585, -16'sd13623, -16'sd15137, -16'sd16069,
        -16'sd16384, -16'sd16069, -16'sd15137, -16'sd13623,
        -16'sd11585, -16'sd9102,  -16'sd6270,  -16'sd3196
    };

    typedef struct packed {
        logic [4:0] slice_index;
        logic [4:0] band_index;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
        logic               last_vertex;
        logic               bad_request;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic [14:0]        radius;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        KIND_TOP,
        KIND_QUAD,
        KIND_BOTTOM,
        KIND_BAD
    } req_kind_t;

    // One classified request: azimuth phases of slice s and s+1, polar
    // phases of the upper and lower row of the band.
    typedef struct packed {
        req_kind_t kind;
        phase_t    ph0;
        phase_t    ph1;
        phase_t    th_a;
        phase_t    th_b;
    } cmd_t;

    // One vertex for the arithmetic pipeline.
    typedef struct packed {
        phase_t ph;
        phase_t th;
        logic   last;
        logic   bad;
    } vtx_req_t;

endpackage

@@ hdl/uvs_front.sv @@
// ----------------------------------------------------------------------------
// uvs_front: request classifier
// Takes request transfers, wraps the slice, classifies the band and turns
// slice and row numbers into table phases for the back end.
// ----------------------------------------------------------------------------
module uvs_front
    import uvs_pkg::*;
#(
    parameter int SLICES = 32,
    parameter int RINGS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output cmd_t     push_data
);

    localparam int NUM_STEPS = 8;

    typedef logic [32:0][PHASE_W-1:0] ph_lut_t;
    typedef logic [31:0][PHASE_W-1:0] th_lut_t;

    // Azimuth phase of slice i, rounded to the nearest table step.
    function automatic ph_lut_t build_ph_lut();
        ph_lut_t lut;
        for (int i = 0; i < 33; i++)
        begin
            lut[i] = PHASE_W'(((i * 64 + SLICES) / (2 * SLICES)) % 32);
        end
        return lut;
    endfunction

    // Polar phase of row k, rounded to the nearest table step.
    function automatic th_lut_t build_th_lut();
        th_lut_t lut;
        for (int k = 0; k < 32; k++)
        begin
            lut[k] = PHASE_W'(((k * 32 + RINGS) / (2 * RINGS)) % 32);
        end
        return lut;
    endfunction

    localparam ph_lut_t PH_LUT = build_ph_lut();
    localparam th_lut_t TH_LUT = build_th_lut();

    logic [4:0] slice_mod;
    logic [5:0] slice_inc;
    logic [7:0] band_wide;
    logic [4:0] row_a;
    req_kind_t  kind;

    // The slice field is at most 31, so a few compare-and-subtract steps
    // bring it below SLICES for every allowed SLICES.
    always_comb
    begin
        slice_mod = in_data.slice_index;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if ({4'd0, slice_mod} >= 9'(SLICES))
            begin
                slice_mod = slice_mod - 5'(SLICES);
            end
        end
    end

    assign slice_inc = ({4'd0, slice_mod} + 9'd1 == 9'(SLICES)) ? 6'd0
                                                                 : {1'b0, slice_mod} + 6'd1;

    assign band_wide = {3'd0, in_data.band_index};

    always_comb
    begin
        priority if (band_wide > 8'(RINGS))
        begin
            kind = KIND_BAD;
        end
        else if (band_wide == 8'd0)
        begin
            kind = KIND_TOP;
        end
        else if (band_wide == 8'(RINGS))
        begin
            kind = KIND_BOTTOM;
        end
        else
        begin
            kind = KIND_QUAD;
        end
    end

    // Upper row of the band; the bottom fan only occurs when RINGS fits the
    // band field, so its row number fits five bits.
    always_comb
    begin
        unique case (kind)
            KIND_TOP:    row_a = 5'd0;
            KIND_BOTTOM: row_a = 5'(RINGS - 1);
            KIND_QUAD:   row_a = in_data.band_index - 5'd1;
            default:     row_a = 5'd0;
        endcase
    end

    assign push_data.kind = kind;
    assign push_data.ph0  = PH_LUT[{1'b0, slice_mod}];
    assign push_data.ph1  = PH_LUT[slice_inc];
    assign push_data.th_a = TH_LUT[row_a];
    assign push_data.th_b = TH_LUT[in_data.band_index];

    assign push_valid = in_valid && rst_n;
    assign in_ready   = push_ready;

    // The classifier itself holds no state; clk is kept for a uniform port set.
    logic unused_clk;
    assign unused_clk = clk;

endmodule

@@ hdl/uvs_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// uvs_cmd_fifo: command queue between front end and back end
// A two-entry queue so that the classifier and the vertex sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module uvs_cmd_fifo
    import uvs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg;
    logic [CMD_PTR_W:0]   count_next;
    logic                 push_fire;
    logic                 pop_fire;

    assign push_ready = (count_reg != (CMD_PTR_W+1)'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign push_fire = push_valid && push_ready;
    assign pop_fire  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{CMD_PTR_W{1'b0}}, push_fire}
                                - {{CMD_PTR_W{1'b0}}, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/uvs_back.sv @@
// ----------------------------------------------------------------------------
// uvs_back: vertex sequencer
// Expands the command at the head of the queue into its vertices, one per
// cycle while the pipeline accepts them; its final vertex retires the command.
// ----------------------------------------------------------------------------
module uvs_back
    import uvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  cmd_t     cmd,
    output logic     vtx_valid,
    input  logic     vtx_ready,
    output vtx_req_t vtx
);

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [2:0] final_step;
    logic       vtx_fire;
    logic       is_last;

    always_comb
    begin
        vtx.bad    = 1'b0;
        vtx.ph     = cmd.ph0;
        vtx.th     = cmd.th_a;
        final_step = 3'd2;
        unique case (cmd.kind)
            KIND_TOP:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        vtx.ph = PH_POLE;
                        vtx.th = TH_NORTH;
                    end
                    3'd1:    vtx.ph = cmd.ph0;
                    default: vtx.ph = cmd.ph1;
                endcase
            end
            KIND_BOTTOM:
            begin
                unique case (step_reg)
                    3'd0:    vtx.ph = cmd.ph0;
                    3'd1:
                    begin
                        vtx.ph = PH_POLE;
                        vtx.th = TH_SOUTH;
                    end
                    default: vtx.ph = cmd.ph1;
                endcase
            end
            KIND_QUAD:
            begin
                final_step = 3'd5;
                // Two triangles: (s,j) (s,j+1) (s+1,j) and (s+1,j) (s,j+1) (s+1,j+1).
                unique case (step_reg)
                    3'd0:
                    begin
                        vtx.ph = cmd.ph0;
                        vtx.th = cmd.th_a;
                    end
                    3'd1, 3'd4:
                    begin
                        vtx.ph = cmd.ph0;
                        vtx.th = cmd.th_b;
                    end
                    3'd2, 3'd3:
                    begin
                        vtx.ph = cmd.ph1;
                        vtx.th = cmd.th_a;
                    end
                    default:
                    begin
                        vtx.ph = cmd.ph1;
                        vtx.th = cmd.th_b;
                    end
                endcase
            end
            default:
            begin
                vtx.bad    = 1'b1;
                final_step = 3'd0;
            end
        endcase
        vtx.last = (step_reg == final_step);
    end

    assign is_last   = vtx.last;
    assign vtx_valid = cmd_valid;
    assign vtx_fire  = vtx_valid && vtx_ready;
    assign cmd_ready = vtx_fire && is_last;

    always_comb
    begin
        step_next = step_reg;
        if (vtx_fire)
        begin
            step_next = is_last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hdl/uvs_vertex_pipe.sv @@
// ----------------------------------------------------------------------------
// uvs_vertex_pipe: vertex arithmetic pipeline
// Four stages: sine lookup, angle product, radius product, then rounding,
// center offset and saturation into the output register.
// ----------------------------------------------------------------------------
module uvs_vertex_pipe
    import uvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_regs_t cfg,
    input  logic      vtx_valid,
    output logic      vtx_ready,
    input  vtx_req_t  vtx,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic signed [47:0] HALF_LSB = 48'sd134217728;

    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en0;
    logic en1;
    logic en2;
    logic en3;

    sine_t sth0_reg;
    sine_t cth0_reg;
    sine_t sph0_reg;
    sine_t cph0_reg;
    logic  last0_reg;
    logic  bad0_reg;

    logic signed [31:0] abx1_reg;
    logic signed [31:0] aby1_reg;
    logic signed [31:0] abz1_reg;
    logic signed [31:0] abx1_next;
    logic signed [31:0] aby1_next;
    logic               last1_reg;
    logic               bad1_reg;

    logic signed [47:0] px2_reg;
    logic signed [47:0] py2_reg;
    logic signed [47:0] pz2_reg;
    logic signed [47:0] px2_next;
    logic signed [47:0] py2_next;
    logic signed [47:0] pz2_next;
    logic signed [15:0] radius_s;
    logic               last2_reg;
    logic               bad2_reg;

    out_item_t out_reg;
    out_item_t out_next;

    // Round half away from zero by 2^28, add the center, saturate to 16 bits.
    function automatic logic signed [15:0] finish(input logic signed [47:0] p,
                                                  input logic signed [15:0] c);
        logic [47:0]        rsum;
        logic signed [17:0] t;
        logic signed [18:0] sum;
        logic signed [15:0] res;
        rsum = p + HALF_LSB - {47'd0, p[47]};
        t    = rsum[45:28];
        sum  = {{3{c[15]}}, c} + {t[17], t};
        if (sum > 19'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (sum < -19'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = sum[15:0];
        end
        return res;
    endfunction

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign vtx_ready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= vtx_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_comb
    begin
        abx1_next = 32'(sth0_reg) * 32'(cph0_reg);
        aby1_next = 32'(sth0_reg) * 32'(sph0_reg);
    end

    assign radius_s = $signed({1'b0, cfg.radius});

    always_comb
    begin
        px2_next = 48'(abx1_reg) * 48'(radius_s);
        py2_next = 48'(aby1_reg) * 48'(radius_s);
        pz2_next = 48'(abz1_reg) * 48'(radius_s);
    end

    always_comb
    begin
        out_next.last_vertex = last2_reg;
        out_next.bad_request = bad2_reg;
        if (bad2_reg)
        begin
            out_next.vert_x = '0;
            out_next.vert_y = '0;
            out_next.vert_z = '0;
        end
        else
        begin
            out_next.vert_x = finish(px2_reg, cfg.center_x);
            out_next.vert_y = finish(py2_reg, cfg.center_y);
            out_next.vert_z = finish(pz2_reg, cfg.center_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            sth0_reg  <= SINE_TABLE[vtx.th];
            cth0_reg  <= SINE_TABLE[vtx.th + QUARTER];
            sph0_reg  <= SINE_TABLE[vtx.ph];
            cph0_reg  <= SINE_TABLE[vtx.ph + QUARTER];
            last0_reg <= vtx.last;
            bad0_reg  <= vtx.bad;
        end
        if (en1)
        begin
            abx1_reg  <= abx1_next;
            aby1_reg  <= aby1_next;
            // The z term has cos(theta) times one, a plain shift into Q2.28.
            abz1_reg  <= {{2{cth0_reg[15]}}, cth0_reg, 14'd0};
            last1_reg <= last0_reg;
            bad1_reg  <= bad0_reg;
        end
        if (en2)
        begin
            px2_reg   <= px2_next;
            py2_reg   <= py2_next;
            pz2_reg   <= pz2_next;
            last2_reg <= last1_reg;
            bad2_reg  <= bad1_reg;
        end
        if (en3)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/uv_sphere_triangle_generator_top.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_triangle_generator_top: UV sphere triangle generator
// Turns (slice, band) requests into the triangle vertices of a
// latitude/longitude sphere with a programmable center and radius.
// ----------------------------------------------------------------------------
// Each request transfer names a longitude slice and a latitude band. Band 0
// answers with the three vertices of the top fan (north pole first), bands 1
// to RINGS-1 with six vertices forming the two triangles of a quad, band RINGS
// with the three vertices of the bottom fan (south pole in the middle), and a
// larger band with a single all-zero vertex that has bad_request and
// last_vertex set. last_vertex marks the final vertex of every request. The
// block delivers one vertex per clock cycle while the output is not stalled;
// that rate is set by the vertex sequencer, which feeds the four-stage
// arithmetic pipeline one vertex at a time. The first vertex of a request
// passes the command queue, the sine lookup, angle product and radius
// product registers and the output register before it is offered, and waits
// longer when earlier requests occupy the queue or the output is stalled. A
// request is classified on entry and parked in a two-entry command queue, so
// while it has room, new requests are taken during expansion and output stalls.
// Slices at or above SLICES wrap modulo SLICES. Coordinates are signed Q7.8;
// each sphere term is rounded half away from zero and the sum with the
// center saturates to 16 bits. The center and radius registers are written
// through the cfg port (index 0..2 center x/y/z, 3 radius) and must only be
// changed while no request is in flight; the radius resets to 2.0.
// ----------------------------------------------------------------------------
module uv_sphere_triangle_generator_top
    import uvs_pkg::*;
#(
    parameter int SLICES = 32,
    parameter int RINGS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    logic     push_valid;
    logic     push_ready;
    cmd_t     push_data;
    logic     cmd_valid;
    logic     cmd_ready;
    cmd_t     cmd;
    logic     vtx_valid;
    logic     vtx_ready;
    vtx_req_t vtx;

    // Configuration registers take effect on the write cycle's edge.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: cfg_next.center_x = cfg_data;
                CFG_CENTER_Y: cfg_next.center_y = cfg_data;
                CFG_CENTER_Z: cfg_next.center_z = cfg_data;
                CFG_RADIUS:   cfg_next.radius   = cfg_data[14:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.center_z <= '0;
            cfg_reg.radius   <= RADIUS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify the request and compute its table phases.
    uvs_front #(
        .SLICES (SLICES),
        .RINGS  (RINGS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue between classification and vertex expansion.
    uvs_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd)
    );

    // Back end: one vertex per cycle from the head command, while the pipeline accepts.
    uvs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx)
    );

    // Arithmetic pipeline; its last stage is the output register.
    uvs_vertex_pipe u_vertex_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hdl/uvs_checker.sv @@
// ----------------------------------------------------------------------------
// uvs_checker: port-level checks of the UV sphere triangle generator
// Watches the request and vertex channels and checks the output handshake,
// the error vertex format and that no vertex appears without a request.
// ----------------------------------------------------------------------------
module uvs_checker
    import uvs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Requests whose final vertex has not yet been transferred.
    logic [3:0] open_reg;
    logic [3:0] open_next;
    logic       in_fire;
    logic       last_fire;

    assign in_fire   = in_valid && in_ready;
    assign last_fire = out_valid && out_ready && out_data.last_vertex;

    always_comb
    begin
        open_next = open_reg + {3'd0, in_fire} - {3'd0, last_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 4'd0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("vertex withdrawn before its transfer");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("vertex changed while stalled");

    a_bad_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_request |->
            out_data.last_vertex && out_data.vert_x == 16'sd0
            && out_data.vert_y == 16'sd0 && out_data.vert_z == 16'sd0)
        else $error("error vertex is not a single zero vertex");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 4'd0)
        else $error("vertex offered with no open request");

    // The slice field is not checked here; it only selects geometry.
    logic [4:0] unused_slice;
    assign unused_slice = in_data.slice_index;

endmodule

bind uv_sphere_triangle_generator_top uvs_checker u_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UV sphere triangle generator
// Sends (slice, band) requests through the valid/ready input channel, works
// out the expected triangle vertices of each request with an independent
// fixed-point sphere model, and compares every vertex that leaves the block.
// A short directed table comes first. Random requests follow under several
// center and radius settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import uvs_pkg::*;

    localparam int NUM_SLICES      = 32;
    localparam int NUM_RINGS       = 16;
    localparam int RANDOM_SETTINGS = 8;
    localparam int ITEMS_PER_SET   = 25;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 20;
    // The slowest correct run is about 215 requests of six vertices each,
    // with the receiver stalled or the sender idle 79 percent of the time;
    // the limit below is sized from such a run.
    localparam int CYCLE_LIMIT     = 200000;

    // Full-wave sine in Q1.14, 32 steps per turn, as built into the block.
    localparam logic signed [15:0] SINE_Q14 [32] = '{
        16'sd0,      16'sd3196,   16'sd6270,   16'sd9102,
        16'sd11585,  16'sd13623,  16'sd15137,  16'sd16069,
        16'sd16384,  16'sd16069,  16'sd15137,  16'sd13623,
        16'sd11585,  16'sd9102,   16'sd6270,   16'sd3196,
        16'sd0,      -16'sd3196,  -16'sd6270,  -16'sd9102,
        -16'sd11585, -16'sd13623, -16'sd15137, -16'sd16069,
        -16'sd16384, -16'sd16069, -16'sd15137, -16'sd13623,
        -16'sd11585, -16'sd9102,  -16'sd6270,  -16'sd3196
    };

    // A band beyond the bottom fan answers with one all-zero vertex that
    // carries both the last and the bad flag.
    localparam out_item_t BAD_VERTEX = '{
        vert_x: 16'sd0, vert_y: 16'sd0, vert_z: 16'sd0,
        last_vertex: 1'b1, bad_request: 1'b1
    };
    localparam out_item_t NOT_TYPED = '0;

    // One row of the directed table. Where typed is set, the row carries the
    // single vertex it must produce; otherwise the sphere model predicts it.
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 13;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Top fan at the first and the last slice; the last one wraps.
        '{req: '{slice_index: 5'd0,  band_index: 5'd0},  typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd31, band_index: 5'd0},  typed: 1'b0, want: NOT_TYPED},
        // Bottom fan at both ends of the slice range.
        '{req: '{slice_index: 5'd0,  band_index: 5'd16}, typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd31, band_index: 5'd16}, typed: 1'b0, want: NOT_TYPED},
        // First and last quad band, then a few from the middle.
        '{req: '{slice_index: 5'd0,  band_index: 5'd1},  typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd31, band_index: 5'd15}, typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd8,  band_index: 5'd8},  typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd21, band_index: 5'd10}, typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd10, band_index: 5'd5},  typed: 1'b0, want: NOT_TYPED},
        '{req: '{slice_index: 5'd16, band_index: 5'd4},  typed: 1'b0, want: NOT_TYPED},
        // Bands out of range: the smallest, the largest and one between.
        '{req: '{slice_index: 5'd0,  band_index: 5'd17}, typed: 1'b1, want: BAD_VERTEX},
        '{req: '{slice_index: 5'd31, band_index: 5'd31}, typed: 1'b1, want: BAD_VERTEX},
        '{req: '{slice_index: 5'd5,  band_index: 5'd24}, typed: 1'b1, want: BAD_VERTEX}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // The bench's own copy of the sphere registers.
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [14:0]        radius;

    out_item_t pending_vertices [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int mismatches;
    int vertices_seen;
    int cycle_count;
    int top_fans;
    int quad_rows;
    int bottom_fans;
    int bad_bands;
    int settings_used;

    uv_sphere_triangle_generator_top #(
        .SLICES (NUM_SLICES),
        .RINGS  (NUM_RINGS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sphere model
    // ------------------------------------------------------------------------

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // radius * a * b carries 36 fraction bits; bring it back to Q7.8 with
    // rounding half away from zero.
    function automatic longint sphere_term(longint a, longint b);
        longint prod;
        longint mag;
        longint quo;
        prod = longint'(radius) * a * b;
        mag  = (prod < 0) ? -prod : prod;
        quo  = (mag + (longint'(1) << 27)) >> 28;
        return (prod < 0) ? -quo : quo;
    endfunction

    // Vertex on latitude row k at slice s; both angles snap to table steps.
    function automatic out_item_t grid_vertex(int s, int k, bit last);
        int        ph;
        int        th;
        longint    sin_th;
        longint    cos_th;
        longint    sin_ph;
        longint    cos_ph;
        out_item_t v;
        ph     = ((s * 64 + NUM_SLICES) / (2 * NUM_SLICES)) % 32;
        th     = ((k * 32 + NUM_RINGS) / (2 * NUM_RINGS)) % 32;
        sin_th = longint'(SINE_Q14[th]);
        cos_th = longint'(SINE_Q14[(th + 8) % 32]);
        sin_ph = longint'(SINE_Q14[ph]);
        cos_ph = longint'(SINE_Q14[(ph + 8) % 32]);
        v.vert_x      = clamp16(longint'(center_x) + sphere_term(sin_th, cos_ph));
        v.vert_y      = clamp16(longint'(center_y) + sphere_term(sin_th, sin_ph));
        v.vert_z      = clamp16(longint'(center_z) + sphere_term(cos_th, 16384));
        v.last_vertex = last;
        v.bad_request = 1'b0;
        return v;
    endfunction

    // North pole for dz = +radius, south pole for dz = -radius.
    function automatic out_item_t pole_vertex(longint dz);
        out_item_t v;
        v.vert_x      = center_x;
        v.vert_y      = center_y;
        v.vert_z      = clamp16(longint'(center_z) + dz);
        v.last_vertex = 1'b0;
        v.bad_request = 1'b0;
        return v;
    endfunction

    // Appends one vertex to the list the block still owes.
    function automatic void owe_vertex(out_item_t v);
        pending_vertices = {pending_vertices, v};
    endfunction

    task automatic predict_triangles(in_item_t req);
        int        s;
        int        s1;
        int        b;
        int        j;
        out_item_t near_low;
        out_item_t far_up;
        s  = int'(req.slice_index) % NUM_SLICES;
        s1 = (s + 1) % NUM_SLICES;
        b  = int'(req.band_index);
        if (b > NUM_RINGS)
        begin
            owe_vertex(BAD_VERTEX);
        end
        else if (b == 0)
        begin
            owe_vertex(pole_vertex(longint'(radius)));
            owe_vertex(grid_vertex(s, 0, 1'b0));
            owe_vertex(grid_vertex(s1, 0, 1'b1));
        end
        else if (b == NUM_RINGS)
        begin
            owe_vertex(grid_vertex(s, NUM_RINGS - 1, 1'b0));
            owe_vertex(pole_vertex(-longint'(radius)));
            owe_vertex(grid_vertex(s1, NUM_RINGS - 1, 1'b1));
        end
        else
        begin
            // Two triangles of the quad share the lower-left and upper-right
            // corners, so those two vertices appear twice.
            j        = b - 1;
            near_low = grid_vertex(s, j + 1, 1'b0);
            far_up   = grid_vertex(s1, j, 1'b0);
            owe_vertex(grid_vertex(s, j, 1'b0));
            owe_vertex(near_low);
            owe_vertex(far_up);
            owe_vertex(far_up);
            owe_vertex(near_low);
            owe_vertex(grid_vertex(s1, j + 1, 1'b1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One register write. The write enable drops again at the edge that takes the
    // write, so a run of writes leaves the enable low between transfers.
    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CENTER_X: center_x = value;
            CFG_CENTER_Y: center_y = value;
            CFG_CENTER_Z: center_z = value;
            CFG_RADIUS:   radius   = value[14:0];
            default: ;
        endcase
    endtask

    // Offers one request and returns at the edge where it is transferred.
    // Each step touches in_valid at most once: either the idle loop lowers
    // it, or it is raised (or kept high) for the new request.
    task automatic send_request(in_item_t req, logic typed, out_item_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            owe_vertex(want);
        else
            predict_triangles(req);
        if (req.band_index == 0)
            top_fans++;
        else if (req.band_index < NUM_RINGS)
            quad_rows++;
        else if (req.band_index == NUM_RINGS)
            bottom_fans++;
        else
            bad_bands++;
    endtask

    // Mostly well-formed bands with a bias toward the two fans, and some
    // bands past the bottom fan.
    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        pick            = $urandom_range(0, 99);
        req.slice_index = 5'($urandom_range(0, 31));
        if (pick < 12)
            req.band_index = 5'd0;
        else if (pick < 24)
            req.band_index = 5'(NUM_RINGS);
        else if (pick < 86)
            req.band_index = 5'($urandom_range(1, NUM_RINGS - 1));
        else
            req.band_index = 5'($urandom_range(NUM_RINGS + 1, 31));
        return req;
    endfunction

    task automatic wait_drained();
        while (pending_vertices.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and vertex checker
    // ------------------------------------------------------------------------

    // The receiver stalls at random in the phases that ask for it.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) < rx_stall_pct) ? 1'b0 : 1'b1;

    task automatic log_mismatch(string why, out_item_t want, out_item_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("Mismatch (%s) at cycle %0d:", why, cycle_count);
            $display("  expected x=%0d y=%0d z=%0d last=%0b bad=%0b",
                     want.vert_x, want.vert_y, want.vert_z,
                     want.last_vertex, want.bad_request);
            $display("  got      x=%0d y=%0d z=%0d last=%0b bad=%0b",
                     got.vert_x, got.vert_y, got.vert_z,
                     got.last_vertex, got.bad_request);
        end
    endtask

    // Every vertex transfer is matched against the oldest vertex still owed.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            vertices_seen++;
            if (pending_vertices.size() == 0)
            begin
                log_mismatch("no vertex expected", NOT_TYPED, out_data);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (out_data.vert_x !== want.vert_x || out_data.vert_y !== want.vert_y
                    || out_data.vert_z !== want.vert_z
                    || out_data.last_vertex !== want.last_vertex
                    || out_data.bad_request !== want.bad_request)
                    log_mismatch("wrong field", want, out_data);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d vertices still owed",
                     cycle_count, pending_vertices.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [15:0] rd;
        int          mode;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CENTER_X;
        cfg_data      = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        mismatches    = 0;
        vertices_seen = 0;
        cycle_count   = 0;
        top_fans      = 0;
        quad_rows     = 0;
        bottom_fans   = 0;
        bad_bands     = 0;
        settings_used = 1;

        // Register values after reset: centered at the origin, radius 2.0.
        center_x = 16'sd0;
        center_y = 16'sd0;
        center_z = 16'sd0;
        radius   = RADIUS_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset settings, back to back with no
        // idling on either side.
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
        in_valid <= 1'b0;
        wait_drained();

        // Random requests under a new center and radius per round. The first
        // rounds push the registers to their extremes: saturation high and
        // low (the low one also sets the unused top bit of the radius write),
        // a zero radius, and a mix of opposite extremes. The rest are random.
        for (int setting = 1; setting <= RANDOM_SETTINGS; setting++)
        begin
            case (setting)
                1:
                begin
                    cx = 16'h7FFF; cy = 16'h7FFF; cz = 16'h7FFF; rd = 16'h7FFF;
                end
                2:
                begin
                    cx = 16'h8000; cy = 16'h8000; cz = 16'h8000; rd = 16'hFFFF;
                end
                3:
                begin
                    cx = 16'h0000; cy = 16'h0000; cz = 16'h0000; rd = 16'h0000;
                end
                4:
                begin
                    cx = 16'h8000; cy = 16'h7FFF; cz = 16'h0000; rd = 16'h7FFF;
                end
                default:
                begin
                    cx = 16'($urandom_range(0, 65535));
                    cy = 16'($urandom_range(0, 65535));
                    cz = 16'($urandom_range(0, 65535));
                    rd = 16'($urandom_range(0, 65535));
                end
            endcase
            write_register(CFG_CENTER_X, cx);
            write_register(CFG_CENTER_Y, cy);
            write_register(CFG_CENTER_Z, cz);
            write_register(CFG_RADIUS, rd);
            settings_used++;

            // Idle patterns cycle through: sender mostly idle, receiver
            // mostly stalled, both lightly, and none at all.
            mode         = setting % 4;
            tx_idle_pct  = (mode == 1) ? 79 : (mode == 3) ? 16 : 0;
            rx_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 16 : 0;

            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                // Halfway through, the sender holds off until the block has
                // delivered every vertex it owes, so it restarts from empty.
                if (n == ITEMS_PER_SET / 2)
                begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_request(random_request(), 1'b0, NOT_TYPED);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        // Let any stray vertex surface before the verdict.
        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests sent: %0d top fans, %0d quad rows, %0d bottom fans, %0d bad bands",
                 top_fans, quad_rows, bottom_fans, bad_bands);
        $display("Vertices checked: %0d under %0d register settings, %0d mismatches",
                 vertices_seen, settings_used, mismatches);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/uvs_pkg.sv
hdl/uvs_front.sv
hdl/uvs_cmd_fifo.sv
hdl/uvs_back.sv
hdl/uvs_vertex_pipe.sv
hdl/uv_sphere_triangle_generator_top.sv
hdl/uvs_checker.sv
test/testbench.sv
